[hw/rtl/casfd_pkg.sv]
// shared types, constants and the crc-8 step for the checked sample frame decoder
// no dependencies; every other rtl file imports this package
`default_nettype none

package casfd_pkg;

  localparam int BYTE_W = 8;
  localparam int WORD_W = 16;
  localparam int POS_W  = 4;
  localparam int TEMP_W = 15;
  localparam int HUM_W  = 14;
  localparam int BAD_W  = 2;
  localparam int PROD_W = 31;  // 65535 * 17500 fits in 31 bits

  localparam logic [POS_W-1:0]  LAST_POS = 4'd8;
  localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

  localparam logic [PROD_W-1:0] TEMP_SCALE  = 31'd17500;
  localparam logic [PROD_W-1:0] HUM_SCALE   = 31'd10000;
  localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd4500;

  typedef enum logic [BAD_W-1:0] {
    BAD_NONE = 2'd0,
    BAD_CO2  = 2'd1,
    BAD_TEMP = 2'd2,
    BAD_HUM  = 2'd3
  } bad_word_t;

  typedef enum logic [1:0] {
    SLOT_HI  = 2'd0,
    SLOT_LO  = 2'd1,
    SLOT_CRC = 2'd2
  } slot_t;

  // raw words of a finished frame plus the first failing word
  typedef struct packed {
    logic [WORD_W-1:0] co2_word;
    logic [WORD_W-1:0] temp_word;
    logic [WORD_W-1:0] hum_word;
    bad_word_t         bad;
  } sample_t;

  // msb-first crc-8 over one byte, no final xor
  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < BYTE_W; i++) begin
      c = c[BYTE_W-1] ? ({c[BYTE_W-2:0], 1'b0} ^ CRC_POLY) : {c[BYTE_W-2:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/casfd_if.sv]
// valid/ready channel interfaces for the reply bytes and the decoded samples
// depends on casfd_pkg
`default_nettype none

interface casfd_in_if import casfd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              frame_start;

  modport source(output valid, output data_byte, output frame_start, input ready);
  modport sink(input valid, input data_byte, input frame_start, output ready);
endinterface

interface casfd_out_if import casfd_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [WORD_W-1:0]        co2_ppm;
  logic signed [TEMP_W-1:0] temperature_centi_c;
  logic [HUM_W-1:0]         humidity_centi_pct;
  logic                     sample_valid;
  logic [BAD_W-1:0]         bad_word;

  modport source(output valid, output co2_ppm, output temperature_centi_c,
                 output humidity_centi_pct, output sample_valid, output bad_word,
                 input ready);
  modport sink(input valid, input co2_ppm, input temperature_centi_c,
               input humidity_centi_pct, input sample_valid, input bad_word,
               output ready);
endinterface

`default_nettype wire

[hw/rtl/casfd_frame.sv]
// byte position tracking, per-word crc check and word assembly
// depends on casfd_pkg
`default_nettype none

module casfd_frame import casfd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic              frame_start,
  output logic                   done,
  output sample_t                sample
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] crc_r, crc_nxt;
  logic [BYTE_W-1:0] high_r, high_nxt;
  logic [WORD_W-1:0] co2_r, co2_nxt;
  logic [WORD_W-1:0] temp_r, temp_nxt;
  logic [WORD_W-1:0] hum_r, hum_nxt;
  bad_word_t         fail_r, fail_nxt;

  logic [POS_W-1:0]  pos_eff;
  logic [BYTE_W-1:0] crc_base;
  bad_word_t         fail_base;
  slot_t             slot;
  bad_word_t         word_code;
  logic [WORD_W-1:0] word_val;

  always_comb begin
    pos_eff   = (frame_start || pos_r > LAST_POS) ? '0 : pos_r;
    crc_base  = (pos_eff == '0) ? CRC_INIT : crc_r;
    fail_base = (pos_eff == '0) ? BAD_NONE : fail_r;
    word_val  = {high_r, data_byte};

    unique case (pos_eff)
      4'd0: begin slot = SLOT_HI;  word_code = BAD_CO2;  end
      4'd1: begin slot = SLOT_LO;  word_code = BAD_CO2;  end
      4'd2: begin slot = SLOT_CRC; word_code = BAD_CO2;  end
      4'd3: begin slot = SLOT_HI;  word_code = BAD_TEMP; end
      4'd4: begin slot = SLOT_LO;  word_code = BAD_TEMP; end
      4'd5: begin slot = SLOT_CRC; word_code = BAD_TEMP; end
      4'd6: begin slot = SLOT_HI;  word_code = BAD_HUM;  end
      4'd7: begin slot = SLOT_LO;  word_code = BAD_HUM;  end
      default: begin slot = SLOT_CRC; word_code = BAD_HUM; end
    endcase

    crc_nxt  = crc_base;
    high_nxt = high_r;
    co2_nxt  = co2_r;
    temp_nxt = temp_r;
    hum_nxt  = hum_r;
    fail_nxt = fail_base;

    unique case (slot)
      SLOT_HI: begin
        crc_nxt  = crc8_update(crc_base, data_byte);
        high_nxt = data_byte;
      end
      SLOT_LO: begin
        crc_nxt = crc8_update(crc_base, data_byte);
        unique case (word_code)
          BAD_CO2:  co2_nxt  = word_val;
          BAD_TEMP: temp_nxt = word_val;
          default:  hum_nxt  = word_val;
        endcase
      end
      default: begin
        // only the first mismatching word is kept
        if (crc_base != data_byte && fail_base == BAD_NONE) begin
          fail_nxt = word_code;
        end
        crc_nxt = CRC_INIT;
      end
    endcase

    pos_nxt = (pos_eff == LAST_POS) ? '0 : pos_eff + 1'b1;
  end

  assign done   = take && (pos_eff == LAST_POS);
  assign sample = '{co2_word: co2_r, temp_word: temp_r, hum_word: hum_r, bad: fail_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      crc_r  <= CRC_INIT;
      high_r <= '0;
      co2_r  <= '0;
      temp_r <= '0;
      hum_r  <= '0;
      fail_r <= BAD_NONE;
    end else if (take) begin
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
      high_r <= high_nxt;
      co2_r  <= co2_nxt;
      temp_r <= temp_nxt;
      hum_r  <= hum_nxt;
      fail_r <= fail_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/casfd_scale.sv]
// two-stage scaling of the raw words into engineering units, with output register
// depends on casfd_pkg and casfd_if
`default_nettype none

module casfd_scale import casfd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     load,
  input  wire sample_t  sample,
  output logic          can_load,
  casfd_out_if.source   out_bus
);

  // floor(x / 65535), exact while the quotient stays below 65536
  function automatic logic [WORD_W-1:0] div_65535(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] sum;
    sum = {1'b0, x} + {17'b0, x[PROD_W-1:WORD_W]} + 1'b1;
    return sum[PROD_W:WORD_W];
  endfunction

  // stage 1: products
  logic              s1_valid_r, s1_valid_nxt;
  logic [WORD_W-1:0] s1_co2_r;
  logic [PROD_W-1:0] s1_tprod_r;
  logic [PROD_W-1:0] s1_hprod_r;
  bad_word_t         s1_bad_r;

  // stage 2: result register
  logic                     out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]        out_co2_r, out_co2_nxt;
  logic signed [TEMP_W-1:0] out_temp_r, out_temp_nxt;
  logic [HUM_W-1:0]         out_hum_r, out_hum_nxt;
  logic                     out_ok_r, out_ok_nxt;
  logic [BAD_W-1:0]         out_bad_r, out_bad_nxt;

  logic              out_free;
  logic              s1_adv;
  logic [WORD_W-1:0] t_quot;
  logic [WORD_W-1:0] h_quot;

  assign out_free = !out_valid_r || out_bus.ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign can_load = !s1_valid_r || out_free;

  always_comb begin
    t_quot = div_65535(s1_tprod_r);
    h_quot = div_65535(s1_hprod_r);

    s1_valid_nxt  = load || (s1_valid_r && !out_free);
    out_valid_nxt = s1_adv || (out_valid_r && !out_bus.ready);

    if (s1_bad_r == BAD_NONE) begin
      out_co2_nxt  = s1_co2_r;
      out_temp_nxt = $signed(t_quot[TEMP_W-1:0] - TEMP_OFFSET);
      out_hum_nxt  = h_quot[HUM_W-1:0];
      out_ok_nxt   = 1'b1;
    end else begin
      out_co2_nxt  = '0;
      out_temp_nxt = '0;
      out_hum_nxt  = '0;
      out_ok_nxt   = 1'b0;
    end
    out_bad_nxt = s1_bad_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      s1_co2_r   <= sample.co2_word;
      s1_tprod_r <= {15'b0, sample.temp_word} * TEMP_SCALE;
      s1_hprod_r <= {15'b0, sample.hum_word} * HUM_SCALE;
      s1_bad_r   <= sample.bad;
    end
    if (s1_adv) begin
      out_co2_r  <= out_co2_nxt;
      out_temp_r <= out_temp_nxt;
      out_hum_r  <= out_hum_nxt;
      out_ok_r   <= out_ok_nxt;
      out_bad_r  <= out_bad_nxt;
    end
  end

  assign out_bus.valid               = out_valid_r;
  assign out_bus.co2_ppm             = out_co2_r;
  assign out_bus.temperature_centi_c = out_temp_r;
  assign out_bus.humidity_centi_pct  = out_hum_r;
  assign out_bus.sample_valid        = out_ok_r;
  assign out_bus.bad_word            = out_bad_r;

endmodule

`default_nettype wire

[hw/rtl/checked_air_sample_frame_decoder.sv]
// Decodes a nine-byte sensor reply, taken one byte per beat, into one checked sample:
// three big-endian words, each followed by a crc-8 byte (poly 0x31, init 0xFF). A byte
// is accepted every cycle while in_bus.ready is high; frame_start restarts the frame at
// the current byte, and without it the position wraps after the ninth byte. The
// constant multiplies are registered at the edge that takes the ninth byte, and the
// divide-by-65535 correction and offset go into the output register once it is free.
// in_bus.ready only drops when both of those stages hold a sample and the output is
// stalled. On a crc failure the values read zero and bad_word names the first
// failing word.
// depends on casfd_pkg, casfd_if, casfd_frame and casfd_scale
`default_nettype none

module checked_air_sample_frame_decoder import casfd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  casfd_in_if.sink    in_bus,
  casfd_out_if.source out_bus
);

  logic    take;
  logic    done;
  logic    can_load;
  sample_t sample;

  assign in_bus.ready = can_load;
  assign take         = in_bus.valid && can_load;

  casfd_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .data_byte   (in_bus.data_byte),
    .frame_start (in_bus.frame_start),
    .done        (done),
    .sample      (sample)
  );

  casfd_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (done),
    .sample   (sample),
    .can_load (can_load),
    .out_bus  (out_bus)
  );

endmodule

`default_nettype wire

[hw/rtl/casfd_checker.sv]
// port-level checks for the checked sample frame decoder, bound to the top level
// depends on casfd_pkg
`default_nettype none

module casfd_checker import casfd_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic [WORD_W-1:0]        out_co2,
  input wire logic signed [TEMP_W-1:0] out_temp,
  input wire logic [HUM_W-1:0]         out_hum,
  input wire logic                     out_ok,
  input wire logic [BAD_W-1:0]         out_bad
);

  // a stalled sample beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_co2) && $stable(out_temp)
      && $stable(out_hum) && $stable(out_ok) && $stable(out_bad))
    else $error("sample beat changed while stalled");

  // good sample: no failing word, values in range
  a_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ok |-> out_bad == BAD_NONE && out_hum <= 14'd10000
      && out_temp >= -15'sd4500 && out_temp <= 15'sd13000)
    else $error("good sample out of range");

  // failed sample: values cleared and a failing word named
  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_bad != BAD_NONE && out_co2 == '0
      && out_temp == '0 && out_hum == '0)
    else $error("failed sample not cleared");

  // input back-pressure only comes from a stalled output
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

endmodule

bind checked_air_sample_frame_decoder casfd_checker u_casfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_co2   (out_bus.co2_ppm),
  .out_temp  (out_bus.temperature_centi_c),
  .out_hum   (out_bus.humidity_centi_pct),
  .out_ok    (out_bus.sample_valid),
  .out_bad   (out_bus.bad_word)
);

`default_nettype wire
